// ----- rtl/core/skt_pkg.sv -----
package skt_pkg;

   localparam int CAPACITY = 128;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int OP_W      = 2;
   localparam int KEY_W     = 34;
   localparam int BAL_W     = 24;
   localparam int POS_W     = 8;
   localparam int ST_W      = 2;
   localparam int CNT_OUT_W = 8;
   localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

   // request layout, lowest bit first: operation, entry_key, entry_balance, position
   localparam int REQ_KEY_LSB = OP_W;
   localparam int REQ_BAL_LSB = REQ_KEY_LSB + KEY_W;
   localparam int REQ_POS_LSB = REQ_BAL_LSB + BAL_W;
   localparam int REQ_W       = ((REQ_POS_LSB + POS_W + 7) / 8) * 8;

   // response layout, lowest bit first: status, read_key, read_balance, entry_count
   localparam int RSP_KEY_LSB = ST_W;
   localparam int RSP_BAL_LSB = RSP_KEY_LSB + KEY_W;
   localparam int RSP_CNT_LSB = RSP_BAL_LSB + BAL_W;
   localparam int RSP_W       = ((RSP_CNT_LSB + CNT_OUT_W + 7) / 8) * 8;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_MISSING = 2'd2,
      ST_BADPOS  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RA_POS   = 2'd0,
      RA_BELOW = 2'd1,
      RA_AT    = 2'd2,
      RA_ABOVE = 2'd3
   } raddr_type;

   typedef enum logic [1:0] {
      WR_NONE = 2'd0,
      WR_NEW  = 2'd1,
      WR_MOVE = 2'd2
   } wr_type;

   typedef enum logic [1:0] {
      IX_HOLD = 2'd0,
      IX_INC  = 2'd1,
      IX_DEC  = 2'd2
   } ix_type;

   typedef struct packed {
      logic       latch;
      raddr_type  raddr;
      wr_type     wr;
      ix_type     ix;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       set_st;
      status_type st;
      logic       take_read;
      logic       load_out;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   idx_zero;
      logic   at_end;
      logic   shift_end;
      logic   pos_bad;
      logic   key_gt;
      logic   key_eq;
   } sts_type;

endpackage

// ----- rtl/core/skt_dp.sv -----
module skt_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  skt_pkg::cmd_type             cmd,
   output skt_pkg::sts_type             sts,
   input  skt_pkg::op_type              in_op,
   input  logic [skt_pkg::KEY_W-1:0]    in_key,
   input  logic [skt_pkg::BAL_W-1:0]    in_bal,
   input  logic [skt_pkg::POS_W-1:0]    in_pos,
   output skt_pkg::status_type          out_status,
   output logic [skt_pkg::KEY_W-1:0]    out_key,
   output logic [skt_pkg::BAL_W-1:0]    out_bal,
   output logic [skt_pkg::CNT_OUT_W-1:0] out_count
);

   typedef struct packed {
      logic [skt_pkg::KEY_W-1:0] key;
      logic [skt_pkg::BAL_W-1:0] bal;
   } entry_type;

   entry_type store_ff [skt_pkg::CAPACITY];
   entry_type rdata_ff;

   skt_pkg::op_type             op_ff;
   logic [skt_pkg::KEY_W-1:0]   key_ff;
   logic [skt_pkg::BAL_W-1:0]   bal_ff;
   logic [skt_pkg::POS_W-1:0]   pos_ff;

   logic [skt_pkg::CNT_W-1:0]   idx_ff, idx_in;
   logic [skt_pkg::CNT_W-1:0]   count_ff, count_in;

   skt_pkg::status_type         res_st_ff;
   logic [skt_pkg::KEY_W-1:0]   res_key_ff;
   logic [skt_pkg::BAL_W-1:0]   res_bal_ff;

   skt_pkg::status_type         out_st_ff;
   logic [skt_pkg::KEY_W-1:0]   out_key_ff;
   logic [skt_pkg::BAL_W-1:0]   out_bal_ff;
   logic [skt_pkg::CNT_OUT_W-1:0] out_cnt_ff;

   logic [skt_pkg::ADDR_W-1:0]  raddr;
   logic [skt_pkg::ADDR_W-1:0]  waddr;
   logic                        we;
   entry_type                   wdata;

   always_comb begin
      unique case (cmd.raddr)
         skt_pkg::RA_POS:   raddr = skt_pkg::ADDR_W'(pos_ff - skt_pkg::POS_W'(1));
         skt_pkg::RA_BELOW: raddr = skt_pkg::ADDR_W'(idx_ff - skt_pkg::CNT_W'(1));
         skt_pkg::RA_AT:    raddr = skt_pkg::ADDR_W'(idx_ff);
         skt_pkg::RA_ABOVE: raddr = skt_pkg::ADDR_W'(idx_ff + skt_pkg::CNT_W'(1));
         default:           raddr = skt_pkg::ADDR_W'(idx_ff);
      endcase
   end

   always_comb begin
      waddr = skt_pkg::ADDR_W'(idx_ff);
      unique case (cmd.wr)
         skt_pkg::WR_NEW: begin
            we    = 1'b1;
            wdata = '{key: key_ff, bal: bal_ff};
         end
         skt_pkg::WR_MOVE: begin
            we    = 1'b1;
            wdata = rdata_ff;
         end
         default: begin
            we    = 1'b0;
            wdata = rdata_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.latch) begin
         idx_in = (in_op == skt_pkg::OP_INSERT) ? count_ff : '0;
      end else begin
         unique case (cmd.ix)
            skt_pkg::IX_INC: idx_in = idx_ff + skt_pkg::CNT_W'(1);
            skt_pkg::IX_DEC: idx_in = idx_ff - skt_pkg::CNT_W'(1);
            default:         idx_in = idx_ff;
         endcase
      end
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + skt_pkg::CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - skt_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.latch) begin
         op_ff      <= in_op;
         key_ff     <= in_key;
         bal_ff     <= in_bal;
         pos_ff     <= in_pos;
         res_st_ff  <= skt_pkg::ST_OK;
         res_key_ff <= '0;
         res_bal_ff <= '0;
      end else begin
         if (cmd.set_st) begin
            res_st_ff <= cmd.st;
         end
         if (cmd.take_read) begin
            res_key_ff <= rdata_ff.key;
            res_bal_ff <= rdata_ff.bal;
         end
      end
      if (cmd.load_out) begin
         out_st_ff  <= res_st_ff;
         out_key_ff <= res_key_ff;
         out_bal_ff <= res_bal_ff;
         out_cnt_ff <= skt_pkg::CNT_OUT_W'(count_ff);
      end
   end

   always_comb begin
      sts.op        = op_ff;
      sts.full      = (count_ff == skt_pkg::CNT_W'(skt_pkg::CAPACITY));
      sts.idx_zero  = (idx_ff == '0);
      sts.at_end    = (idx_ff == count_ff);
      sts.shift_end = ((skt_pkg::CNT_W+1)'(idx_ff) + (skt_pkg::CNT_W+1)'(1))
                      >= (skt_pkg::CNT_W+1)'(count_ff);
      sts.pos_bad   = (pos_ff == '0)
                      || (skt_pkg::CMP_W'(pos_ff) > skt_pkg::CMP_W'(count_ff));
      sts.key_gt    = (rdata_ff.key > key_ff);
      sts.key_eq    = (rdata_ff.key == key_ff);
   end

   assign out_status = out_st_ff;
   assign out_key    = out_key_ff;
   assign out_bal    = out_bal_ff;
   assign out_count  = out_cnt_ff;

endmodule

// ----- rtl/core/skt_ctrl.sv -----
module skt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  skt_pkg::sts_type sts,
   output skt_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_INS_RD,
      S_INS_CMP,
      S_RM_RD,
      S_RM_CMP,
      S_SH_RD,
      S_SH_WR,
      S_RD_GET,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      valid_in = valid_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.op)
               skt_pkg::OP_INSERT: begin
                  if (sts.full) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = skt_pkg::ST_FULL;
                     state_in   = S_DONE;
                  end else begin
                     state_in = S_INS_RD;
                  end
               end
               skt_pkg::OP_REMOVE: state_in = S_RM_RD;
               skt_pkg::OP_READ: begin
                  if (sts.pos_bad) begin
                     cmd.set_st = 1'b1;
                     cmd.st     = skt_pkg::ST_BADPOS;
                     state_in   = S_DONE;
                  end else begin
                     cmd.raddr = skt_pkg::RA_POS;
                     state_in  = S_RD_GET;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         // walk down from the top, moving larger keys up one slot
         S_INS_RD: begin
            if (sts.idx_zero) begin
               cmd.wr      = skt_pkg::WR_NEW;
               cmd.cnt_inc = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.raddr = skt_pkg::RA_BELOW;
               state_in  = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            if (sts.key_gt) begin
               cmd.wr   = skt_pkg::WR_MOVE;
               cmd.ix   = skt_pkg::IX_DEC;
               state_in = S_INS_RD;
            end else begin
               cmd.wr      = skt_pkg::WR_NEW;
               cmd.cnt_inc = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_RM_RD: begin
            if (sts.at_end) begin
               cmd.set_st = 1'b1;
               cmd.st     = skt_pkg::ST_MISSING;
               state_in   = S_DONE;
            end else begin
               cmd.raddr = skt_pkg::RA_AT;
               state_in  = S_RM_CMP;
            end
         end
         S_RM_CMP: begin
            if (sts.key_eq) begin
               state_in = S_SH_RD;
            end else begin
               cmd.ix   = skt_pkg::IX_INC;
               state_in = S_RM_RD;
            end
         end
         // close the gap: pull each later entry down one slot
         S_SH_RD: begin
            if (sts.shift_end) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end else begin
               cmd.raddr = skt_pkg::RA_ABOVE;
               state_in  = S_SH_WR;
            end
         end
         S_SH_WR: begin
            cmd.wr   = skt_pkg::WR_MOVE;
            cmd.ix   = skt_pkg::IX_INC;
            state_in = S_SH_RD;
         end
         S_RD_GET: begin
            cmd.take_read = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (!valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               valid_in     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = valid_ff;

endmodule

// ----- rtl/core/sorted_key_table_top.sv -----
// channel | direction | ports                 | payload
// request | in        | req_tvalid/tready/tdata | operation, entry_key, entry_balance, position
// result  | out       | rsp_tvalid/tready/tdata | status, read_key, read_balance, entry_count
//
// One request at a time. A read passes dispatch and the entry read before its result;
// bad-position, full and no-op requests go from dispatch straight to the result; insert
// and remove walk the table one entry at a time, reading each entry and then moving it.
// The next request is taken in the cycle after the result is loaded.
// A stalled result sits in the output register while the next request is taken.
// Reset is synchronous and clears the entry count; entry memory is not cleared.
module sorted_key_table_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // operation, entry_key, entry_balance, position, zero fill
   input  logic [skt_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // status, read_key, read_balance, entry_count, zero fill
   output logic [skt_pkg::RSP_W-1:0]   rsp_tdata
);

   skt_pkg::cmd_type              cmd;
   skt_pkg::sts_type              sts;
   skt_pkg::status_type           out_status;
   logic [skt_pkg::KEY_W-1:0]     out_key;
   logic [skt_pkg::BAL_W-1:0]     out_bal;
   logic [skt_pkg::CNT_OUT_W-1:0] out_count;

   skt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   skt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_op      (skt_pkg::op_type'(req_tdata[skt_pkg::OP_W-1:0])),
      .in_key     (req_tdata[skt_pkg::REQ_KEY_LSB +: skt_pkg::KEY_W]),
      .in_bal     (req_tdata[skt_pkg::REQ_BAL_LSB +: skt_pkg::BAL_W]),
      .in_pos     (req_tdata[skt_pkg::REQ_POS_LSB +: skt_pkg::POS_W]),
      .out_status (out_status),
      .out_key    (out_key),
      .out_bal    (out_bal),
      .out_count  (out_count)
   );

   assign rsp_tdata = {
      (skt_pkg::RSP_W - skt_pkg::RSP_CNT_LSB - skt_pkg::CNT_OUT_W)'(0),
      out_count, out_bal, out_key, out_status
   };

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (out_count <= skt_pkg::CNT_OUT_W'(skt_pkg::CAPACITY)))
      else $error("entry count above capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_status == skt_pkg::ST_FULL)
      |-> (out_count == skt_pkg::CNT_OUT_W'(skt_pkg::CAPACITY)))
      else $error("full status with table not full");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_status != skt_pkg::ST_OK) |-> (out_key == '0 && out_bal == '0))
      else $error("read fields set on an error result");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.cnt_inc && cmd.cnt_dec))
      else $error("count raised and lowered at once");
`endif

endmodule
